// ----- rtl/core/csfg_pkg.sv -----
// Package for the counting semaphore granter: command and event codes,
// register indexes, shared types and the capacity lookup. No dependencies.
`default_nettype none

package csfg_pkg;

  localparam int MAX_RES   = 8;
  localparam int RES_W     = 3;
  localparam int PROC_W    = 8;
  localparam int CAP_W     = 3;
  localparam int CYC_OUT_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int CNT_W     = 4;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MUTEX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_TABLE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_REQ,
    CMD_TICK,
    CMD_BAD
  } cmd_kind_t;

  typedef enum logic [2:0] {
    EV_GRANT_NOW   = 3'd0,
    EV_QUEUED      = 3'd1,
    EV_QUEUE_GRANT = 3'd2,
    EV_BAD_RES     = 3'd3,
    EV_QUEUE_FULL  = 3'd4,
    EV_TICK_DONE   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [PROC_W-1:0] proc;
    logic [RES_W-1:0]  res;
  } cmd_t;

  function automatic logic [CAP_W-1:0] cap_of(input logic mutex,
                                               input logic [CFG_DAT_W-1:0] tbl,
                                               input logic [RES_W-1:0] idx);
    logic [CAP_W-1:0] c;
    c = tbl[CAP_W*idx +: CAP_W];
    return mutex ? CAP_W'(1) : c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csfg_front.sv -----
// Front end: takes input items and classifies them as request, tick or
// bad resource. Depends on csfg_pkg.
`default_nettype none

module csfg_front
  import csfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_operation,
  input  wire logic [PROC_W-1:0] in_process_id,
  input  wire logic [RES_W-1:0]  in_resource_index,
  input  wire logic [CNT_W-1:0]  valid_cnt,
  input  wire logic              fifo_full,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic seen_r;
  logic seen_nxt;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;
  assign seen_nxt = seen_r || push;

  always_comb begin
    push_cmd.proc = in_process_id;
    push_cmd.res  = in_resource_index;
    if (in_operation) begin
      push_cmd.kind = CMD_TICK;
    end else if ({1'b0, in_resource_index} >= valid_cnt) begin
      push_cmd.kind = CMD_BAD;
    end else begin
      push_cmd.kind = CMD_REQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/csfg_cmd_fifo.sv -----
// Short command queue between front and back end.
// Depends on csfg_pkg.
`default_nettype none

module csfg_cmd_fifo
  import csfg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      not_empty
);

  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t                 store_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;

  assign full      = (count_r == CW'(CMD_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/csfg_back.sv -----
// Back end: held counts, wait queues in one memory, cycle counter, tick
// sequencer and the result register. Depends on csfg_pkg.
`default_nettype none

module csfg_back
  import csfg_pkg::*;
#(
  parameter int NUM_RESOURCES = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYCLE_LIMIT   = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  input  cmd_t                      cmd,
  output logic                      cmd_pop,
  input  wire logic                 mutex_mode,
  input  wire logic [CFG_DAT_W-1:0] cap_table,
  input  wire logic [CNT_W-1:0]     valid_cnt,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_event_kind,
  output logic [PROC_W-1:0]         out_granted_process,
  output logic [RES_W-1:0]          out_granted_resource,
  output logic [CYC_OUT_W-1:0]      out_cycle_number,
  output logic                      out_last
);

  localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = LW + 1;
  localparam int MD  = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int CW  = (CYCLE_LIMIT > 1) ? $clog2(CYCLE_LIMIT) : 1;

  logic [PROC_W-1:0] mem [MD];
  logic [PROC_W-1:0] rd_data_r;

  logic [CAP_W-1:0] held_r [MAX_RES];
  logic [HW-1:0]    head_r [MAX_RES];
  logic [LW-1:0]    len_r  [MAX_RES];
  logic [CW-1:0]    cyc_r, cyc_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  state_t           state_r, state_nxt;

  logic              out_valid_r;
  logic [2:0]        kind_r;
  logic [PROC_W-1:0] proc_r;
  logic [RES_W-1:0]  res_r;
  logic [CW-1:0]     ocyc_r;
  logic              last_r;

  logic              out_free;
  logic [RES_W-1:0]  r_idx;
  logic              scan_end;
  logic              can_grant;
  logic              held_ok;
  logic              q_full;
  logic [SW-1:0]     slot_sum;
  logic [HW-1:0]     slot;
  logic [HW-1:0]     head_inc;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       cyc_wide;

  logic              emit;
  event_t            emit_kind;
  logic [PROC_W-1:0] emit_proc;
  logic [RES_W-1:0]  emit_res;
  logic              emit_last;
  logic              do_tick;
  logic              do_grant_now;
  logic              do_enqueue;
  logic              do_queue_grant;
  logic              scan_inc;
  logic              rd_en;

  assign out_free  = !out_valid_r || out_ready;
  assign r_idx     = scan_r[RES_W-1:0];
  assign scan_end  = (scan_r >= valid_cnt);
  assign can_grant = (held_r[r_idx] < cap_of(mutex_mode, cap_table, r_idx)) &&
                     (len_r[r_idx] != '0);
  assign held_ok   = held_r[cmd.res] < cap_of(mutex_mode, cap_table, cmd.res);
  assign q_full    = (len_r[cmd.res] == LW'(QUEUE_DEPTH));
  assign slot_sum  = SW'(head_r[cmd.res]) + SW'(len_r[cmd.res]);
  assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - SW'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc  = (head_r[r_idx] == HW'(QUEUE_DEPTH - 1)) ?
                     '0 : head_r[r_idx] + 1'b1;
  assign wr_addr   = AW'(32'(cmd.res) * QUEUE_DEPTH + 32'(slot));
  assign rd_addr   = AW'(32'(r_idx) * QUEUE_DEPTH + 32'(head_r[r_idx]));
  assign cyc_nxt   = (cyc_r == CW'(CYCLE_LIMIT - 1)) ? '0 : cyc_r + 1'b1;
  assign scan_nxt  = do_tick ? '0 : (scan_inc ? scan_r + 1'b1 : scan_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_TICK) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end else if (can_grant) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    emit           = 1'b0;
    emit_kind      = EV_TICK_DONE;
    emit_proc      = '0;
    emit_res       = '0;
    emit_last      = 1'b1;
    do_tick        = 1'b0;
    do_grant_now   = 1'b0;
    do_enqueue     = 1'b0;
    do_queue_grant = 1'b0;
    scan_inc       = 1'b0;
    rd_en          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_TICK) begin
            cmd_pop = 1'b1;
            do_tick = 1'b1;
          end else if (out_free) begin
            cmd_pop   = 1'b1;
            emit      = 1'b1;
            emit_proc = cmd.proc;
            emit_res  = cmd.res;
            if (cmd.kind == CMD_BAD) begin
              emit_kind = EV_BAD_RES;
            end else if (held_ok) begin
              emit_kind    = EV_GRANT_NOW;
              do_grant_now = 1'b1;
            end else if (q_full) begin
              emit_kind = EV_QUEUE_FULL;
            end else begin
              emit_kind  = EV_QUEUED;
              do_enqueue = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          if (can_grant) begin
            rd_en = 1'b1;
          end else begin
            scan_inc = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_kind      = EV_QUEUE_GRANT;
          emit_proc      = rd_data_r;
          emit_res       = r_idx;
          emit_last      = 1'b0;
          do_queue_grant = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_enqueue) begin
      mem[wr_addr] <= cmd.proc;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
        held_r[i] <= '0;
        head_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      if (do_tick) begin
        cyc_r <= cyc_nxt;
        for (int i = 0; i < MAX_RES; i++) begin
          held_r[i] <= '0;
        end
      end
      if (do_grant_now) begin
        held_r[cmd.res] <= held_r[cmd.res] + 1'b1;
      end
      if (do_enqueue) begin
        len_r[cmd.res] <= len_r[cmd.res] + 1'b1;
      end
      if (do_queue_grant) begin
        held_r[r_idx] <= held_r[r_idx] + 1'b1;
        head_r[r_idx] <= head_inc;
        len_r[r_idx]  <= len_r[r_idx] - 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= emit_kind;
      proc_r <= emit_proc;
      res_r  <= emit_res;
      ocyc_r <= cyc_r;
      last_r <= emit_last;
    end
  end

  assign cyc_wide             = 32'(ocyc_r);
  assign out_valid            = out_valid_r;
  assign out_event_kind       = kind_r;
  assign out_granted_process  = proc_r;
  assign out_granted_resource = res_r;
  assign out_cycle_number     = cyc_wide[CYC_OUT_W-1:0];
  assign out_last             = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/counting_semaphore_fifo_granter_unit.sv -----
// Counting semaphore granter with one FIFO wait queue per resource. A
// request is granted at once while its resource has a free slot, is
// otherwise queued and is refused when its wait queue is full; a tick
// releases all grants and serves the queues in index order, closing with a
// tick-done result that has last set. The front end takes one item per
// cycle into a two-entry command queue while that queue is not full. In
// the back end a request or bad index gives one result. A tick runs in
// steps: one to take it, one scan step per valid resource and two per
// queue grant, one to end the scan and one for the tick-done result; each
// queue grant costs one read of the wait-queue memory and one step to hand
// the result on. A stalled result register holds the back end.
// Configuration is taken at any time on the cfg port and is expected only
// while the block is idle. Depends on csfg_pkg.
`default_nettype none

module counting_semaphore_fifo_granter_unit
  import csfg_pkg::*;
#(
  parameter int NUM_RESOURCES = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYCLE_LIMIT   = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_operation,
  input  wire logic [PROC_W-1:0]    in_process_id,
  input  wire logic [RES_W-1:0]     in_resource_index,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_event_kind,
  output logic [PROC_W-1:0]         out_granted_process,
  output logic [RES_W-1:0]          out_granted_resource,
  output logic [CYC_OUT_W-1:0]      out_cycle_number,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic                 mutex_r;
  logic [CNT_W-1:0]     in_use_r;
  logic [CFG_DAT_W-1:0] cap_r;
  logic [CNT_W-1:0]     valid_cnt;
  logic                 cfg_we;

  logic fifo_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t pop_cmd;
  logic not_empty;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign valid_cnt = (in_use_r > CNT_W'(NUM_RESOURCES)) ? CNT_W'(NUM_RESOURCES) : in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mutex_r  <= 1'b1;
      in_use_r <= '0;
      cap_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MUTEX_MODE: mutex_r  <= cfg_data[0];
        CFG_RES_IN_USE: in_use_r <= cfg_data[CNT_W-1:0];
        CFG_CAP_TABLE:  cap_r    <= cfg_data;
        default:        mutex_r  <= mutex_r;
      endcase
    end
  end

  csfg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_process_id     (in_process_id),
    .in_resource_index (in_resource_index),
    .valid_cnt         (valid_cnt),
    .fifo_full         (fifo_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  csfg_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  csfg_back #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .CYCLE_LIMIT   (CYCLE_LIMIT)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (not_empty),
    .cmd                  (pop_cmd),
    .cmd_pop              (pop),
    .mutex_mode           (mutex_r),
    .cap_table            (cap_r),
    .valid_cnt            (valid_cnt),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_kind       (out_event_kind),
    .out_granted_process  (out_granted_process),
    .out_granted_resource (out_granted_resource),
    .out_cycle_number     (out_cycle_number),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire
